// File: hdl/fhd_pkg.sv
// Package for the frame header deframer: header layout constants, register
// indexes, result kinds and the result word type shared by all modules.
// No dependencies.
package fhd_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int KIND_W      = 2;
    localparam int CNT_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CNT_W-1:0] POS_MAGIC_FIRST   = 4'd0;
    localparam logic [CNT_W-1:0] POS_MAGIC_LAST    = 4'd3;
    localparam logic [CNT_W-1:0] POS_VERSION       = 4'd4;
    localparam logic [CNT_W-1:0] POS_TYPE          = 4'd5;
    localparam logic [CNT_W-1:0] POS_REQUEST_FIRST = 4'd8;
    localparam logic [CNT_W-1:0] POS_REQUEST_LAST  = 4'd11;
    localparam logic [CNT_W-1:0] POS_LENGTH_FIRST  = 4'd12;
    localparam logic [CNT_W-1:0] POS_LENGTH_LAST   = 4'd15;

    localparam logic [WORD_W-1:0] RESET_MAGIC       = 32'd0;
    localparam logic [BYTE_W-1:0] RESET_MIN_VERSION = 8'd2;
    localparam logic [BYTE_W-1:0] RESET_MAX_VERSION = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC_WORD  = 2'd0,
        CFG_MIN_VERSION = 2'd1,
        CFG_MAX_VERSION = 2'd2
    } t_cfg_index;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_item_kind;

    typedef struct packed {
        t_item_kind        item_kind;
        logic [BYTE_W-1:0] version;
        logic [BYTE_W-1:0] msg_type;
        logic [WORD_W-1:0] txn_id;
        logic [WORD_W-1:0] payload_length;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_result_push;

endpackage

// File: hdl/fhd_ifs.sv
// Channel interfaces of the frame header deframer: input byte stream,
// result stream and configuration write channel. Depends on fhd_pkg.
interface fhd_byte_if;
    logic                      valid;
    logic                      ready;
    logic [fhd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface fhd_result_if;
    logic                       valid;
    logic                       ready;
    logic [fhd_pkg::KIND_W-1:0] item_kind;
    logic [fhd_pkg::BYTE_W-1:0] version;
    logic [fhd_pkg::BYTE_W-1:0] msg_type;
    logic [fhd_pkg::WORD_W-1:0] txn_id;
    logic [fhd_pkg::WORD_W-1:0] payload_length;
    logic [fhd_pkg::BYTE_W-1:0] payload_byte;
    logic                       frame_last;

    modport source (output valid, output item_kind, output version, output msg_type,
                    output txn_id, output payload_length, output payload_byte,
                    output frame_last, input ready);
    modport sink (input valid, input item_kind, input version, input msg_type,
                  input txn_id, input payload_length, input payload_byte,
                  input frame_last, output ready);
endinterface

interface fhd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fhd_pkg::CFG_IDX_W-1:0]  index;
    logic [fhd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/fhd_parse.sv
// Header parser: configuration registers, header collection state and the
// per-word result logic. Depends on fhd_pkg and fhd_ifs.
module fhd_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fhd_cfg_if.sink               i_cfg,
    fhd_byte_if.sink              i_in,
    input  logic                  i_space,
    output fhd_pkg::t_result_push o_push
);

    logic [fhd_pkg::WORD_W-1:0] r_magic_word;
    logic [fhd_pkg::BYTE_W-1:0] r_min_version;
    logic [fhd_pkg::BYTE_W-1:0] r_max_version;

    logic                       r_in_payload, n_in_payload;
    logic [fhd_pkg::CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [fhd_pkg::WORD_W-1:0] r_magic, n_magic;
    logic [fhd_pkg::BYTE_W-1:0] r_version, n_version;
    logic [fhd_pkg::BYTE_W-1:0] r_type, n_type;
    logic [fhd_pkg::WORD_W-1:0] r_request, n_request;
    logic [fhd_pkg::WORD_W-1:0] r_length, n_length;
    logic [fhd_pkg::WORD_W-1:0] r_remaining, n_remaining;

    logic                       accept;
    logic                       good;
    logic [fhd_pkg::BYTE_W-1:0] b;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_space;
    assign accept      = i_in.valid && i_space;
    assign b           = i_in.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_word  <= fhd_pkg::RESET_MAGIC;
            r_min_version <= fhd_pkg::RESET_MIN_VERSION;
            r_max_version <= fhd_pkg::RESET_MAX_VERSION;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                fhd_pkg::CFG_MAGIC_WORD: begin
                    r_magic_word <= i_cfg.data;
                end
                fhd_pkg::CFG_MIN_VERSION: begin
                    r_min_version <= i_cfg.data[fhd_pkg::BYTE_W-1:0];
                end
                fhd_pkg::CFG_MAX_VERSION: begin
                    r_max_version <= i_cfg.data[fhd_pkg::BYTE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_magic      = r_magic;
        n_version    = r_version;
        n_type       = r_type;
        n_request    = r_request;
        n_length     = r_length;
        n_remaining  = r_remaining;
        o_push       = '0;
        good         = 1'b0;
        if (accept) begin
            if (r_in_payload && (r_remaining != '0)) begin
                o_push.valid               = 1'b1;
                o_push.result.item_kind    = fhd_pkg::KIND_PAYLOAD;
                o_push.result.payload_byte = b;
                o_push.result.frame_last   = (r_remaining == 32'd1);
                n_remaining                = r_remaining - 32'd1;
                if (r_remaining == 32'd1) begin
                    n_in_payload = 1'b0;
                    n_hdr_cnt    = '0;
                end
            end else begin
                n_in_payload = 1'b0;
                case (r_hdr_cnt) inside
                    [fhd_pkg::POS_MAGIC_FIRST:fhd_pkg::POS_MAGIC_LAST]: begin
                        n_magic = {r_magic[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
                    end
                    fhd_pkg::POS_VERSION: begin
                        n_version = b;
                    end
                    fhd_pkg::POS_TYPE: begin
                        n_type = b;
                    end
                    [fhd_pkg::POS_REQUEST_FIRST:fhd_pkg::POS_REQUEST_LAST]: begin
                        n_request = {r_request[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
                    end
                    [fhd_pkg::POS_LENGTH_FIRST:fhd_pkg::POS_LENGTH_LAST]: begin
                        n_length = {r_length[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
                    end
                    default: begin
                    end
                endcase
                if (r_hdr_cnt != fhd_pkg::POS_LENGTH_LAST) begin
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                end else begin
                    n_hdr_cnt    = '0;
                    o_push.valid = 1'b1;
                    good = (r_magic == r_magic_word) && (r_version >= r_min_version)
                        && (r_version <= r_max_version);
                    if (!good) begin
                        o_push.result.item_kind  = fhd_pkg::KIND_ERROR;
                        o_push.result.frame_last = 1'b1;
                    end else begin
                        o_push.result.item_kind      = fhd_pkg::KIND_HEADER;
                        o_push.result.version        = r_version;
                        o_push.result.msg_type       = r_type;
                        o_push.result.txn_id         = r_request;
                        o_push.result.payload_length = n_length;
                        if (n_length == '0) begin
                            o_push.result.frame_last = 1'b1;
                        end else begin
                            n_in_payload = 1'b1;
                            n_remaining  = n_length;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_remaining  <= '0;
        end else begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_remaining  <= n_remaining;
        end
    end

    always_ff @(posedge i_clk) begin
        r_magic   <= n_magic;
        r_version <= n_version;
        r_type    <= n_type;
        r_request <= n_request;
        r_length  <= n_length;
    end

endmodule

// File: hdl/fhd_skid.sv
// Result output stage: an output register with one skid entry behind it,
// so the input side never waits on the output handshake directly.
// Depends on fhd_pkg and fhd_ifs.
module fhd_skid (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fhd_pkg::t_result_push i_push,
    output logic                  o_space,
    fhd_result_if.source          o_out
);

    logic             r_main_valid;
    logic             r_skid_valid;
    fhd_pkg::t_result r_main;
    fhd_pkg::t_result r_skid;
    logic             pop;

    assign pop     = r_main_valid && o_out.ready;
    assign o_space = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push.valid) begin
            if (!r_main_valid || pop) begin
                r_main       <= i_push.result;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_push.result;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    assign o_out.valid          = r_main_valid;
    assign o_out.item_kind      = r_main.item_kind;
    assign o_out.version        = r_main.version;
    assign o_out.msg_type       = r_main.msg_type;
    assign o_out.txn_id         = r_main.txn_id;
    assign o_out.payload_length = r_main.payload_length;
    assign o_out.payload_byte   = r_main.payload_byte;
    assign o_out.frame_last     = r_main.frame_last;

endmodule

// File: hdl/frame_header_deframer_core.sv
// Top level of the frame header deframer: header parser and result stage.
// Depends on fhd_pkg, fhd_ifs, fhd_parse and fhd_skid.
//
//   Channel   Dir   Word carried
//   i_cfg     in    register index and 32-bit write data
//   i_in      in    one stream byte (data_byte)
//   o_out     out   one result (header, payload byte or error)
//
// One word is taken every cycle while ready on i_in is high; each result is
// registered in the output stage. Ready on i_in falls only while the
// output register and its skid entry both hold results that are not taken.
// Reset is synchronous and active low; it restores the register defaults
// and starts a new header. i_cfg is always ready.
module frame_header_deframer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fhd_cfg_if.sink      i_cfg,
    fhd_byte_if.sink     i_in,
    fhd_result_if.source o_out
);

    fhd_pkg::t_result_push push;
    logic                  space;

    fhd_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .i_space (space),
        .o_push  (push)
    );

    fhd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

// File: sim/tb_frame_header_deframer_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for frame_header_deframer_core: directed frames, then random
// frames under three handshake mixes, checked against an in-bench deframer model.
// Depends on hdl/fhd_pkg.sv, hdl/fhd_ifs.sv and the deframer RTL.
module tb_frame_header_deframer_core;

    localparam int ITEM_TARGET = 650;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HEADER_BYTES = 16;
    localparam logic [fhd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct {
        logic [fhd_pkg::BYTE_W-1:0] data;
        bit                         known;
        fhd_pkg::t_result           want;
    } t_stream_word;

    typedef struct packed {
        logic [fhd_pkg::WORD_W-1:0] cfg_magic;
        logic [fhd_pkg::BYTE_W-1:0] cfg_min;
        logic [fhd_pkg::BYTE_W-1:0] cfg_max;
        logic [fhd_pkg::WORD_W-1:0] magic;
        logic [fhd_pkg::BYTE_W-1:0] ver;
        logic [fhd_pkg::BYTE_W-1:0] mtype;
        logic [15:0]                skip;
        logic [fhd_pkg::WORD_W-1:0] reqid;
        logic [fhd_pkg::WORD_W-1:0] len;
        logic                       known;
        fhd_pkg::t_item_kind        known_kind;
    } t_frame_row;

    // Zero length, bad magic, each version bound, the empty version range and
    // ignored header bytes all appear here.
    t_frame_row frame_rows [0:12] = '{
        '{32'h0, 8'd2, 8'd3, 32'h0, 8'd2, 8'h00, 16'h0000, 32'h0, 32'd0, 1'b1,
          fhd_pkg::KIND_HEADER},
        '{32'h0, 8'd2, 8'd3, 32'h0, 8'd3, 8'hFF, 16'hFFFF, 32'hFFFFFFFF, 32'd2, 1'b0,
          fhd_pkg::KIND_HEADER},
        '{32'h0, 8'd2, 8'd3, 32'h1, 8'd2, 8'h11, 16'h1234, 32'h1, 32'hFFFFFFFF, 1'b1,
          fhd_pkg::KIND_ERROR},
        '{32'h0, 8'd2, 8'd3, 32'h0, 8'd1, 8'h22, 16'h0000, 32'h2, 32'd0, 1'b1,
          fhd_pkg::KIND_ERROR},
        '{32'h0, 8'd2, 8'd3, 32'h0, 8'd4, 8'h33, 16'h0000, 32'h3, 32'd0, 1'b1,
          fhd_pkg::KIND_ERROR},
        '{32'hFFFFFFFF, 8'd0, 8'd255, 32'hFFFFFFFF, 8'd0, 8'h5A, 16'hA55A, 32'h80000001,
          32'd1, 1'b0, fhd_pkg::KIND_HEADER},
        '{32'hFFFFFFFF, 8'd0, 8'd255, 32'hFFFFFFFF, 8'd255, 8'hC3, 16'h0F0F, 32'h7FFFFFFE,
          32'd0, 1'b1, fhd_pkg::KIND_HEADER},
        '{32'hFFFFFFFF, 8'd0, 8'd255, 32'h7FFFFFFF, 8'd16, 8'h01, 16'h0000, 32'h4,
          32'h80000000, 1'b1, fhd_pkg::KIND_ERROR},
        '{32'h12345678, 8'h80, 8'h7F, 32'h12345678, 8'h80, 8'h02, 16'h0000, 32'h5, 32'd0,
          1'b1, fhd_pkg::KIND_ERROR},
        '{32'h12345678, 8'h80, 8'h7F, 32'h12345678, 8'h7F, 8'h03, 16'h0000, 32'h6, 32'd0,
          1'b1, fhd_pkg::KIND_ERROR},
        '{32'hA5A5A5A5, 8'd0, 8'd0, 32'hA5A5A5A5, 8'd0, 8'h44, 16'hFFFF, 32'h00FF00FF,
          32'd3, 1'b0, fhd_pkg::KIND_HEADER},
        '{32'hA5A5A5A5, 8'd255, 8'd255, 32'hA5A5A5A5, 8'd255, 8'h55, 16'h0000, 32'hFF00FF00,
          32'd0, 1'b1, fhd_pkg::KIND_HEADER},
        '{32'hA5A5A5A5, 8'd255, 8'd255, 32'hA5A5A5A5, 8'd254, 8'h66, 16'h0000, 32'h7,
          32'd0, 1'b1, fhd_pkg::KIND_ERROR}
    };

    logic i_clk;
    logic i_rst_n;

    fhd_byte_if   in_bus ();
    fhd_result_if out_bus ();
    fhd_cfg_if    cfg_bus ();

    frame_header_deframer_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_stream_word     byte_stream[$];
    fhd_pkg::t_result awaited_results[$];
    t_stream_word     word_on_bus;

    int send_idle_pct;
    int recv_idle_pct;
    int bytes_queued = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int cfg_writes = 0;
    int headers_seen = 0;
    int payload_seen = 0;
    int rejects_seen = 0;

    logic [fhd_pkg::WORD_W-1:0] cfg_magic;
    logic [fhd_pkg::BYTE_W-1:0] cfg_min_ver;
    logic [fhd_pkg::BYTE_W-1:0] cfg_max_ver;

    logic                       in_payload;
    logic [fhd_pkg::CNT_W-1:0]  hdr_pos;
    logic [fhd_pkg::WORD_W-1:0] magic_sr;
    logic [fhd_pkg::BYTE_W-1:0] ver_hold;
    logic [fhd_pkg::BYTE_W-1:0] type_hold;
    logic [fhd_pkg::WORD_W-1:0] reqid_sr;
    logic [fhd_pkg::WORD_W-1:0] len_sr;
    logic [fhd_pkg::WORD_W-1:0] remaining;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic reset_deframer_model();
        cfg_magic = fhd_pkg::RESET_MAGIC;
        cfg_min_ver = fhd_pkg::RESET_MIN_VERSION;
        cfg_max_ver = fhd_pkg::RESET_MAX_VERSION;
        in_payload = 1'b0;
        hdr_pos = '0;
        magic_sr = '0;
        ver_hold = '0;
        type_hold = '0;
        reqid_sr = '0;
        len_sr = '0;
        remaining = '0;
    endtask

    task automatic deframe_byte(input logic [fhd_pkg::BYTE_W-1:0] b, output bit got,
                                output fhd_pkg::t_result r);
        r = '0;
        got = 1'b0;
        if (in_payload && remaining != 0) begin
            r.item_kind = fhd_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            r.frame_last = (remaining == 1);
            remaining = remaining - 1;
            if (remaining == 0) begin
                in_payload = 1'b0;
                hdr_pos = '0;
            end
            got = 1'b1;
        end else begin
            in_payload = 1'b0;
            if (hdr_pos <= fhd_pkg::POS_MAGIC_LAST) begin
                magic_sr = {magic_sr[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
            end else if (hdr_pos == fhd_pkg::POS_VERSION) begin
                ver_hold = b;
            end else if (hdr_pos == fhd_pkg::POS_TYPE) begin
                type_hold = b;
            end else if (hdr_pos >= fhd_pkg::POS_REQUEST_FIRST &&
                         hdr_pos <= fhd_pkg::POS_REQUEST_LAST) begin
                reqid_sr = {reqid_sr[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
            end else if (hdr_pos >= fhd_pkg::POS_LENGTH_FIRST) begin
                len_sr = {len_sr[fhd_pkg::WORD_W-fhd_pkg::BYTE_W-1:0], b};
            end
            if (hdr_pos != fhd_pkg::POS_LENGTH_LAST) begin
                hdr_pos = hdr_pos + 1'b1;
            end else begin
                hdr_pos = '0;
                got = 1'b1;
                if (magic_sr != cfg_magic || ver_hold < cfg_min_ver || ver_hold > cfg_max_ver)
                begin
                    r.item_kind = fhd_pkg::KIND_ERROR;
                    r.frame_last = 1'b1;
                end else begin
                    r.item_kind = fhd_pkg::KIND_HEADER;
                    r.version = ver_hold;
                    r.msg_type = type_hold;
                    r.txn_id = reqid_sr;
                    r.payload_length = len_sr;
                    if (len_sr == 0) begin
                        r.frame_last = 1'b1;
                    end else begin
                        in_payload = 1'b1;
                        remaining = len_sr;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [fhd_pkg::WORD_W-1:0] want,
                               input logic [fhd_pkg::WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result();
        fhd_pkg::t_result w;
        if (awaited_results.size() == 0) begin
            $display("%0t: result kind %h with nothing awaited", $time, out_bus.item_kind);
            mismatches++;
        end else begin
            w = awaited_results.pop_front();
            check_field("item_kind", 32'(w.item_kind), 32'(out_bus.item_kind));
            check_field("version", 32'(w.version), 32'(out_bus.version));
            check_field("msg_type", 32'(w.msg_type), 32'(out_bus.msg_type));
            check_field("txn_id", w.txn_id, out_bus.txn_id);
            check_field("payload_length", w.payload_length, out_bus.payload_length);
            check_field("payload_byte", 32'(w.payload_byte), 32'(out_bus.payload_byte));
            check_field("frame_last", 32'(w.frame_last), 32'(out_bus.frame_last));
            case (w.item_kind)
                fhd_pkg::KIND_HEADER: headers_seen++;
                fhd_pkg::KIND_PAYLOAD: payload_seen++;
                default: rejects_seen++;
            endcase
        end
    endtask

    always @(posedge i_clk) begin : monitor
        bit got;
        fhd_pkg::t_result r;
        if (!i_rst_n) begin
            reset_deframer_model();
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    fhd_pkg::CFG_MAGIC_WORD: cfg_magic = cfg_bus.data;
                    fhd_pkg::CFG_MIN_VERSION: cfg_min_ver = cfg_bus.data[fhd_pkg::BYTE_W-1:0];
                    fhd_pkg::CFG_MAX_VERSION: cfg_max_ver = cfg_bus.data[fhd_pkg::BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (in_bus.valid && in_bus.ready) begin
                deframe_byte(in_bus.data_byte, got, r);
                if (got) begin
                    awaited_results.push_back(word_on_bus.known ? word_on_bus.want : r);
                end
            end
            if (out_bus.valid && out_bus.ready) begin
                check_result();
            end
        end
    end

    always @(posedge i_clk) begin : byte_driver
        t_stream_word s;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_bus.ready) begin
            if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s = byte_stream.pop_front();
                in_bus.valid <= 1'b1;
                in_bus.data_byte <= s.data;
                word_on_bus <= s;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_bus.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out with %0d results awaited", $time,
                     awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (byte_stream.size() != 0 || in_bus.valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [fhd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fhd_pkg::WORD_W-1:0] val);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic program_regs(input logic [fhd_pkg::WORD_W-1:0] magic,
                                input logic [fhd_pkg::BYTE_W-1:0] lo,
                                input logic [fhd_pkg::BYTE_W-1:0] hi);
        wait_idle();
        write_reg(fhd_pkg::CFG_MAGIC_WORD, magic);
        write_reg(fhd_pkg::CFG_MIN_VERSION, {24'($urandom), lo});
        write_reg(fhd_pkg::CFG_MAX_VERSION, {24'($urandom), hi});
        write_reg(CFG_UNUSED_INDEX, $urandom);
    endtask

    function automatic bit header_passes(input logic [fhd_pkg::WORD_W-1:0] magic,
                                         input logic [fhd_pkg::BYTE_W-1:0] ver);
        return magic == cfg_magic && ver >= cfg_min_ver && ver <= cfg_max_ver;
    endfunction

    task automatic send_frame(input logic [fhd_pkg::WORD_W-1:0] magic,
                              input logic [fhd_pkg::BYTE_W-1:0] ver,
                              input logic [fhd_pkg::BYTE_W-1:0] mtype, input logic [15:0] skip,
                              input logic [fhd_pkg::WORD_W-1:0] reqid,
                              input logic [fhd_pkg::WORD_W-1:0] len,
                              input bit known, input fhd_pkg::t_item_kind known_kind);
        logic [HEADER_BYTES*fhd_pkg::BYTE_W-1:0] hdr;
        t_stream_word s;
        hdr = {magic, ver, mtype, skip, reqid, len};
        for (int i = 0; i < HEADER_BYTES; i++) begin
            s.data = hdr[HEADER_BYTES*fhd_pkg::BYTE_W-1-fhd_pkg::BYTE_W*i -: fhd_pkg::BYTE_W];
            s.known = known && (i == HEADER_BYTES - 1);
            s.want = '0;
            s.want.item_kind = known_kind;
            if (known_kind == fhd_pkg::KIND_HEADER) begin
                s.want.version = ver;
                s.want.msg_type = mtype;
                s.want.txn_id = reqid;
                s.want.payload_length = len;
                s.want.frame_last = (len == 0);
            end else begin
                s.want.frame_last = 1'b1;
            end
            byte_stream.push_back(s);
        end
        bytes_queued += HEADER_BYTES;
        if (header_passes(magic, ver)) begin
            for (int i = 0; i < len; i++) begin
                s.data = 8'($urandom_range(255, 0));
                s.known = 1'b0;
                byte_stream.push_back(s);
            end
            bytes_queued += len;
        end
    endtask

    task automatic random_frame();
        int pick;
        int size_pick;
        logic [fhd_pkg::WORD_W-1:0] magic;
        logic [fhd_pkg::BYTE_W-1:0] ver;
        logic [fhd_pkg::WORD_W-1:0] len;
        pick = $urandom_range(99, 0);
        size_pick = $urandom_range(99, 0);
        magic = cfg_magic;
        ver = 8'((cfg_min_ver <= cfg_max_ver) ? $urandom_range(cfg_max_ver, cfg_min_ver)
                                              : $urandom_range(255, 0));
        if (size_pick < 85) begin
            len = $urandom_range(15, 0);
        end else if (size_pick < 95) begin
            len = $urandom_range(40, 16);
        end else begin
            len = $urandom_range(300, 256);
        end
        if (pick < 10) begin
            magic = $urandom;
            ver = 8'($urandom_range(255, 0));
            len = $urandom;
            if (header_passes(magic, ver)) begin
                magic[0] = ~magic[0];
            end
        end else if (pick < 25) begin
            len = $urandom;
            if (pick < 18 && cfg_min_ver > 0) begin
                ver = 8'($urandom_range(cfg_min_ver - 1, 0));
            end else if (pick >= 18 && cfg_max_ver < 255) begin
                ver = 8'($urandom_range(255, cfg_max_ver + 1));
            end else begin
                magic[$urandom_range(fhd_pkg::WORD_W-1, 0)] ^= 1'b1;
            end
        end
        send_frame(magic, ver, 8'($urandom_range(255, 0)), 16'($urandom_range(16'hFFFF, 0)),
                   $urandom, len, 1'b0, fhd_pkg::KIND_HEADER);
    endtask

    initial begin : stimulus
        logic [fhd_pkg::BYTE_W-1:0] lo;
        logic [fhd_pkg::BYTE_W-1:0] hi;
        logic [fhd_pkg::BYTE_W-1:0] tmp;
        int quota;
        int phase_end;
        int frames;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.data_byte = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        out_bus.ready = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 45;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(frame_rows); k++) begin
            if (frame_rows[k].cfg_magic != cfg_magic || frame_rows[k].cfg_min != cfg_min_ver ||
                frame_rows[k].cfg_max != cfg_max_ver) begin
                program_regs(frame_rows[k].cfg_magic, frame_rows[k].cfg_min,
                             frame_rows[k].cfg_max);
            end
            send_frame(frame_rows[k].magic, frame_rows[k].ver, frame_rows[k].mtype,
                       frame_rows[k].skip, frame_rows[k].reqid, frame_rows[k].len,
                       frame_rows[k].known, frame_rows[k].known_kind);
        end

        for (int phase = 0; phase < 3; phase++) begin
            lo = 8'($urandom_range(255, 0));
            hi = 8'($urandom_range(255, 0));
            if (phase == 0 && lo > hi) begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end else if (phase == 1) begin
                hi = lo;
            end else if (phase == 2) begin
                hi = 8'hFF;
            end
            program_regs($urandom, lo, hi);
            if (phase == 1) begin
                send_idle_pct = 45;
                recv_idle_pct = 19;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            quota = (ITEM_TARGET - bytes_queued) / (3 - phase);
            phase_end = bytes_queued + quota;
            frames = 0;
            while (bytes_queued < phase_end) begin
                random_frame();
                frames++;
                if (frames == 3) begin
                    wait_idle();
                end
            end
        end

        wait_idle();
        $display("Sent %0d stream words through %0d register writes and three handshake mixes.",
                 bytes_queued, cfg_writes);
        $display("Checked %0d accepted headers, %0d rejected headers and %0d payload words.",
                 headers_seen, rejects_seen, payload_seen);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
